// File: sv/prsc_pkg.sv
// ----------------------------------------------------------------------------
// PLL rate setting calculator package
// Shared types, register indexes and constants of the calculator.
// ----------------------------------------------------------------------------
package prsc_pkg;

  localparam int unsigned NumCells  = 64;
  localparam int unsigned AddrWidth = 6;

  localparam logic [2:0]  RegRefFreq  = 3'd0;
  localparam logic [2:0]  RegVcoMin   = 3'd1;
  localparam logic [2:0]  RegVcoMax   = 3'd2;
  localparam logic [2:0]  RegPcwBits  = 3'd3;
  localparam logic [2:0]  RegFracBits = 3'd4;

  localparam logic [31:0] RefFreqRst  = 32'd26000000;
  localparam logic [32:0] VcoMinRst   = 33'd1500000000;
  localparam logic [32:0] VcoMaxRst   = 33'd3800000000;
  localparam logic [5:0]  PcwBitsRst  = 6'd22;
  localparam logic [4:0]  FracBitsRst = 5'd14;

  localparam logic [2:0]  ExpLimit    = 3'd4;
  localparam logic [63:0] RoundHalf   = 64'd50000;
  localparam logic [31:0] RoundStep   = 32'd100000;

  localparam logic FuncSettings = 1'b0;
  localparam logic FuncRate     = 1'b1;

  typedef struct packed {
    logic [31:0] ref_freq;
    logic [32:0] vco_min;
    logic [32:0] vco_max;
    logic [5:0]  pcw_bits;
    logic [4:0]  frac_bits;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        func;
    logic        zero_ref;
    logic [2:0]  exp;
    logic [31:0] rem;
    logic [63:0] dq;
    logic [31:0] dvsr;
    logic [63:0] x;
  } cell_t;

endpackage

// File: sv/prsc_if.sv
// ----------------------------------------------------------------------------
// PLL rate setting calculator channels
// Request and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface prsc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [32:0] target_freq;
  logic [31:0] pcw_raw;
  logic [2:0]  postdiv_code;

  modport source (output valid, func, target_freq, pcw_raw, postdiv_code, input ready);
  modport sink (input valid, func, target_freq, pcw_raw, postdiv_code, output ready);
endinterface

interface prsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pcw_value;
  logic [2:0]  postdiv_exp;
  logic [63:0] rate;

  modport source (output valid, pcw_value, postdiv_exp, rate, input ready);
  modport sink (input valid, pcw_value, postdiv_exp, rate, output ready);
endinterface

// File: sv/prsc_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in a dividend bit, forms a quotient bit.
// ----------------------------------------------------------------------------
module prsc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  prsc_pkg::cell_t cell_i,
  output prsc_pkg::cell_t cell_o
);

  prsc_pkg::cell_t cell_d, cell_q;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  always_comb begin
    trial = {cell_i.rem, cell_i.dq[63]};
    ge    = trial >= {1'b0, cell_i.dvsr};
    diff  = trial - {1'b0, cell_i.dvsr};
    cell_d = cell_i;
    cell_d.rem = ge ? diff[31:0] : trial[31:0];
    cell_d.dq  = {cell_i.dq[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: sv/prsc_front.sv
// ----------------------------------------------------------------------------
// Operand front end
// Clamps the target, picks the exponent and multiplies, then forms the
// dividend and divisor that enter the divider chain.
// ----------------------------------------------------------------------------
module prsc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic            func_i,
  input  logic [32:0]     target_freq_i,
  input  logic [31:0]     pcw_raw_i,
  input  logic [2:0]      postdiv_code_i,
  input  prsc_pkg::cfg_t  cfg_i,
  output prsc_pkg::cell_t cell_o
);

  logic        valid_q;
  logic        func_q;
  logic [2:0]  exp_q, exp_d;
  logic [63:0] div0_q, div0_d;
  logic [63:0] prod_q, prod_d;
  logic [2:0]  code_q;
  logic [32:0] f;
  logic [31:0] pcw;
  logic [63:0] vco;
  logic [63:0] rnd;
  logic [63:0] r;

  always_comb begin
    f = (target_freq_i > cfg_i.vco_max) ? cfg_i.vco_max : target_freq_i;
    exp_d = prsc_pkg::ExpLimit;
    for (int i = 3; i >= 0; i--) begin
      if ((64'(f) << i) >= 64'(cfg_i.vco_min)) begin
        exp_d = 3'(i);
      end
    end
    div0_d = (64'(f) << exp_d) << cfg_i.frac_bits;
    if (cfg_i.pcw_bits == 6'd0) begin
      pcw = '0;
    end else if (cfg_i.pcw_bits < 6'd32) begin
      pcw = pcw_raw_i & ((32'd1 << cfg_i.pcw_bits[4:0]) - 32'd1);
    end else begin
      pcw = pcw_raw_i;
    end
    prod_d = 64'(cfg_i.ref_freq) * 64'(pcw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_q <= func_i;
      exp_q  <= exp_d;
      div0_q <= div0_d;
      prod_q <= prod_d;
      code_q <= postdiv_code_i;
    end
  end

  always_comb begin
    vco = prod_q >> cfg_i.frac_bits;
    rnd = (64'd1 << code_q) - 64'd1;
    r   = (vco + rnd) >> code_q;
    cell_o = '0;
    cell_o.valid    = valid_q;
    cell_o.func     = func_q;
    cell_o.zero_ref = cfg_i.ref_freq == 32'd0;
    cell_o.exp      = exp_q;
    if (func_q == prsc_pkg::FuncRate) begin
      cell_o.x    = r + prsc_pkg::RoundHalf;
      cell_o.dvsr = prsc_pkg::RoundStep;
    end else begin
      cell_o.x    = div0_q;
      cell_o.dvsr = cfg_i.ref_freq;
    end
    cell_o.dq = cell_o.x;
  end

endmodule

// File: sv/pll_rate_setting_calculator.sv
// ----------------------------------------------------------------------------
// PLL rate setting calculator
// Converts target rates to PCW and post-divider settings and back.
// ----------------------------------------------------------------------------
// A request on req_i carries func, a target rate (func 0) or a PCW word and
// post-divider code (func 1). Each request yields one result on res_o: the
// PCW and exponent for func 0, the rate rounded to 100 kHz for func 1.
// The APB port holds the reference rate, the VCO limits and the PCW format;
// the user must write it only while no request is in flight; the block won't check.
// The operand stage with the 32x32 multiplier loads at the accepting edge, a
// row of 64 divider cells each retire one quotient bit, and the result
// register follows. One request is accepted every cycle unless a result stalls.
// When the receiver stalls a valid result, the whole chain holds and req_i
// ready drops until the result is taken.
// Reset empties the chain and restores the register defaults.
// ----------------------------------------------------------------------------
module pll_rate_setting_calculator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  prsc_in_if.sink                            req_i,
  prsc_out_if.source                         res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [prsc_pkg::AddrWidth-1:0]     paddr,
  input  logic [63:0]                        pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);

  prsc_pkg::cfg_t  cfg_q;
  prsc_pkg::cell_t chain [prsc_pkg::NumCells+1];
  prsc_pkg::cell_t last;
  logic            adv;
  logic            out_valid_q;
  logic [31:0]     pcw_q;
  logic [2:0]      exp_q;
  logic [63:0]     rate_q;
  logic [2:0]      idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_freq  <= prsc_pkg::RefFreqRst;
      cfg_q.vco_min   <= prsc_pkg::VcoMinRst;
      cfg_q.vco_max   <= prsc_pkg::VcoMaxRst;
      cfg_q.pcw_bits  <= prsc_pkg::PcwBitsRst;
      cfg_q.frac_bits <= prsc_pkg::FracBitsRst;
    end else if (psel && penable && pwrite) begin
      case (idx)
        prsc_pkg::RegRefFreq:  cfg_q.ref_freq  <= pwdata[31:0];
        prsc_pkg::RegVcoMin:   cfg_q.vco_min   <= pwdata[32:0];
        prsc_pkg::RegVcoMax:   cfg_q.vco_max   <= pwdata[32:0];
        prsc_pkg::RegPcwBits:  cfg_q.pcw_bits  <= pwdata[5:0];
        prsc_pkg::RegFracBits: cfg_q.frac_bits <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      prsc_pkg::RegRefFreq:  prdata = 64'(cfg_q.ref_freq);
      prsc_pkg::RegVcoMin:   prdata = 64'(cfg_q.vco_min);
      prsc_pkg::RegVcoMax:   prdata = 64'(cfg_q.vco_max);
      prsc_pkg::RegPcwBits:  prdata = 64'(cfg_q.pcw_bits);
      prsc_pkg::RegFracBits: prdata = 64'(cfg_q.frac_bits);
      default:               prdata = '0;
    endcase
  end

  assign adv       = !(out_valid_q && !res_o.ready);
  assign req_i.ready = adv;

  prsc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .valid_i        (req_i.valid),
    .func_i         (req_i.func),
    .target_freq_i  (req_i.target_freq),
    .pcw_raw_i      (req_i.pcw_raw),
    .postdiv_code_i (req_i.postdiv_code),
    .cfg_i          (cfg_q),
    .cell_o         (chain[0])
  );

  for (genvar g = 0; g < prsc_pkg::NumCells; g++) begin : g_cell
    prsc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign last = chain[prsc_pkg::NumCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (last.func == prsc_pkg::FuncRate) begin
        pcw_q  <= '0;
        exp_q  <= '0;
        rate_q <= last.x - 64'(last.rem);
      end else begin
        pcw_q  <= last.zero_ref ? '1 : last.dq[31:0];
        exp_q  <= last.exp;
        rate_q <= '0;
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pcw_value   = pcw_q;
  assign res_o.postdiv_exp = exp_q;
  assign res_o.rate        = rate_q;

`ifndef SYNTHESIS
  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> exp_q <= prsc_pkg::ExpLimit)
    else $error("Post-divider exponent out of range.");
  a_rate_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last.valid && last.func == prsc_pkg::FuncRate) |-> last.rem < prsc_pkg::RoundStep)
    else $error("Rounding remainder exceeds the step.");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> out_valid_q && $stable(rate_q) && $stable(pcw_q))
    else $error("Result changed while stalled.");
`endif

endmodule
